// ===== sv/ccma_pkg.sv =====
// Shared types, codes and lookup functions of the cut cell merge averaging block.
`timescale 1ns / 1ps
`default_nettype none
package ccma_pkg;

  // Request type codes on the req_type port.
  localparam logic [1:0] REQ_GEOM    = 2'd0;
  localparam logic [1:0] REQ_VALUE   = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SIZE_X     = 2'd0;
  localparam logic [1:0] CFG_SIZE_Y     = 2'd1;
  localparam logic [1:0] CFG_SIZE_Z     = 2'd2;
  localparam logic [1:0] CFG_COMP_COUNT = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_AVERAGED = 3'd0;
  localparam logic [2:0] ST_PASSED   = 3'd1;
  localparam logic [2:0] ST_COVERED  = 3'd2;
  localparam logic [2:0] ST_LOW_VOL  = 3'd3;
  localparam logic [2:0] ST_OUTSIDE  = 3'd4;
  localparam logic [2:0] ST_BAD_COMP = 3'd5;

  localparam logic signed [31:0] SENTINEL = 32'sh7FFF_FFFF;
  localparam int HALF_VOLUME = 16384;
  localparam int PROD_W = 48;

  // Operation held in the request queue.
  typedef enum logic [1:0] {
    OP_GEOM,
    OP_VALUE,
    OP_COMPUTE
  } op_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [4:0] size_x;
    logic [4:0] size_y;
    logic [4:0] size_z;
    logic [3:0] comp_count;
  } cfg_t;

  // One classified request.
  typedef struct packed {
    op_t               op;
    logic              bad_cell;
    logic              bad_comp;
    logic [11:0]       addr;
    logic [2:0]        comp;
    logic [15:0]       vf;
    logic signed [31:0] value;
    logic [2:0]        cnt;
    logic [34:0]       codes;
  } item_t;

  // Neighbor offset for one code.
  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
    logic signed [1:0] dz;
  } offs_t;

  // Box size as used: zero acts as one, above sixteen acts as sixteen.
  function automatic logic [4:0] eff_size(input logic [4:0] s);
    logic [4:0] r;
    r = s;
    if (s == 5'd0) r = 5'd1;
    else if (s > 5'd16) r = 5'd16;
    return r;
  endfunction

  // Offsets of the 26 neighbor codes; code 0 and codes above 26 are not used.
  function automatic offs_t nbr_off(input logic [4:0] code);
    offs_t o;
    logic [4:0] k;
    o = '0;
    k = 5'd0;
    if (code >= 5'd18) begin
      o.dz = 2'sd1;
      k = code - 5'd18;
    end else if (code >= 5'd9) begin
      o.dz = -2'sd1;
      k = code - 5'd9;
    end
    if (code >= 5'd9) begin
      case (k)
        5'd0: begin o.dx = -2'sd1; o.dy = -2'sd1; end
        5'd1: begin o.dx =  2'sd0; o.dy = -2'sd1; end
        5'd2: begin o.dx =  2'sd1; o.dy = -2'sd1; end
        5'd3: begin o.dx = -2'sd1; o.dy =  2'sd0; end
        5'd4: begin o.dx =  2'sd0; o.dy =  2'sd0; end
        5'd5: begin o.dx =  2'sd1; o.dy =  2'sd0; end
        5'd6: begin o.dx = -2'sd1; o.dy =  2'sd1; end
        5'd7: begin o.dx =  2'sd0; o.dy =  2'sd1; end
        default: begin o.dx = 2'sd1; o.dy = 2'sd1; end
      endcase
    end else begin
      case (code)
        5'd1: begin o.dx = -2'sd1; o.dy = -2'sd1; end
        5'd2: begin o.dx =  2'sd0; o.dy = -2'sd1; end
        5'd3: begin o.dx =  2'sd1; o.dy = -2'sd1; end
        5'd4: begin o.dx = -2'sd1; o.dy =  2'sd0; end
        5'd5: begin o.dx =  2'sd1; o.dy =  2'sd0; end
        5'd6: begin o.dx = -2'sd1; o.dy =  2'sd1; end
        5'd7: begin o.dx =  2'sd0; o.dy =  2'sd1; end
        5'd8: begin o.dx =  2'sd1; o.dy =  2'sd1; end
        default: begin o.dx = 2'sd0; o.dy = 2'sd0; end
      endcase
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== sv/cut_cell_merge_average.sv =====
// Top level of the cut cell merge averaging block.
//
//  channel   signals                                            handshake
//  request   req_type cell_addr comp_index vol_fraction         start & !busy
//            update_value nbor_count nbor_codes
//  result    out_cell out_comp result_value status              done, one cycle
//  config    cfg_index cfg_data                                 cfg_we
//
// A load is written to the stores as it leaves the queue. A merged compute request
// keeps the back end through intake and checks, two coordinate divisions, a pass
// per neighbor through the stores, the volume check and the bit-serial averaging
// division.
// Reset is synchronous; the stores are not cleared and hold no valid bits.
// busy rises when the two-entry request queue is full; results cannot be held off.
`timescale 1ns / 1ps
`default_nettype none
module cut_cell_merge_average import ccma_pkg::*; #(
  parameter int MAX_CELLS = 4096,
  parameter int MAX_COMPONENTS = 8,
  parameter int MAX_NEIGHBORS = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [11:0] cell_addr,
  input  logic [2:0]  comp_index,
  input  logic [15:0] vol_fraction,
  input  logic signed [31:0] update_value,
  input  logic [2:0]  nbor_count,
  input  logic [34:0] nbor_codes,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  output logic        done,
  output logic [11:0] out_cell,
  output logic [2:0]  out_comp,
  output logic signed [31:0] result_value,
  output logic [2:0]  status
);

  cfg_t  cfg;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  // Request intake and queue.
  ccma_front #(.MAX_CELLS(MAX_CELLS), .MAX_COMPONENTS(MAX_COMPONENTS)) u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .cell_addr(cell_addr), .comp_index(comp_index), .vol_fraction(vol_fraction),
    .update_value(update_value), .nbor_count(nbor_count), .nbor_codes(nbor_codes),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  // Stores and compute sequencer.
  ccma_back #(
    .MAX_CELLS(MAX_CELLS), .MAX_COMPONENTS(MAX_COMPONENTS), .MAX_NEIGHBORS(MAX_NEIGHBORS)
  ) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .done(done), .out_cell(out_cell), .out_comp(out_comp),
    .result_value(result_value), .status(status)
  );

endmodule
`default_nettype wire

// ===== sv/ccma_div.sv =====
// Restoring divider for unsigned operands, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ccma_div #(
  parameter int NW = 12,
  parameter int DW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quot,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] q;
  logic [DW-1:0] r;
  logic [DW-1:0] d;
  logic [DW:0]   trial;
  logic [DW-1:0] r_next;
  logic          qbit;

  // One shift and conditional subtract.
  always_comb begin
    trial = {r, q[NW-1]};
    if (trial >= {1'b0, d}) begin
      qbit = 1'b1;
      r_next = DW'(trial - {1'b0, d});
    end else begin
      qbit = 1'b0;
      r_next = trial[DW-1:0];
    end
  end

  // Iteration control and operand registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(NW);
        q <= dividend;
        r <= '0;
        d <= divisor;
      end else if (busy) begin
        r <= r_next;
        q <= {q[NW-2:0], qbit};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q;
  assign rem = r;

endmodule
`default_nettype wire

// ===== sv/ccma_front.sv =====
// Front end: configuration registers, request classification and request queue.
`timescale 1ns / 1ps
`default_nettype none
module ccma_front import ccma_pkg::*; #(
  parameter int MAX_CELLS = 4096,
  parameter int MAX_COMPONENTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [11:0] cell_addr,
  input  logic [2:0]  comp_index,
  input  logic [15:0] vol_fraction,
  input  logic signed [31:0] update_value,
  input  logic [2:0]  nbor_count,
  input  logic [34:0] nbor_codes,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  output cfg_t        cfg,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  item_t      in_item;
  logic       keep;
  logic       push;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size_x <= 5'd16;
      cfg.size_y <= 5'd16;
      cfg.size_z <= 5'd16;
      cfg.comp_count <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIZE_X:     cfg.size_x <= cfg_data;
        CFG_SIZE_Y:     cfg.size_y <= cfg_data;
        CFG_SIZE_Z:     cfg.size_z <= cfg_data;
        CFG_COMP_COUNT: cfg.comp_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Classify the request; loads that miss the stores and idle codes are dropped here.
  always_comb begin
    in_item.op = OP_COMPUTE;
    in_item.bad_cell = 32'(cell_addr) >= MAX_CELLS;
    in_item.bad_comp = (32'(comp_index) >= 32'(cfg.comp_count)) ||
                       (32'(comp_index) >= MAX_COMPONENTS);
    in_item.addr = cell_addr;
    in_item.comp = comp_index;
    in_item.vf = vol_fraction;
    in_item.value = update_value;
    in_item.cnt = nbor_count;
    in_item.codes = nbor_codes;
    case (req_type)
      REQ_GEOM: begin
        in_item.op = OP_GEOM;
        keep = !in_item.bad_cell;
      end
      REQ_VALUE: begin
        in_item.op = OP_VALUE;
        keep = !in_item.bad_cell && (32'(comp_index) < MAX_COMPONENTS);
      end
      REQ_COMPUTE: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  assign busy = (cnt == 2'd2);
  assign push = start && !busy && keep;
  assign q_valid = (cnt != 2'd0);
  assign q_item = slots[rd_ptr];

  // Two-entry request queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ccma_back.sv =====
// Back end: cell stores and the sequencer that loads, gathers neighbors and averages.
`timescale 1ns / 1ps
`default_nettype none
module ccma_back import ccma_pkg::*; #(
  parameter int MAX_CELLS = 4096,
  parameter int MAX_COMPONENTS = 8,
  parameter int MAX_NEIGHBORS = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        done,
  output logic [11:0] out_cell,
  output logic [2:0]  out_comp,
  output logic signed [31:0] result_value,
  output logic [2:0]  status
);

  localparam int CA_W = $clog2(MAX_CELLS);
  localparam int VA_W = $clog2(MAX_CELLS * MAX_COMPONENTS);
  localparam int SUM_W = PROD_W + $clog2(MAX_NEIGHBORS + 1);
  localparam int VSUM_W = 16 + $clog2(MAX_NEIGHBORS + 1);
  localparam logic [2:0] NB_CAP = (MAX_NEIGHBORS >= 7) ? 3'd7 : 3'(MAX_NEIGHBORS);

  typedef enum logic [3:0] {
    S_IDLE, S_SETTLE, S_CHECK, S_OWN, S_ACC0, S_DIVX, S_DIVY,
    S_NCODE, S_NCHK, S_NDATA, S_NACC, S_FIN, S_DIVA
  } state_t;

  state_t state;
  item_t  cur;

  // Stores.
  logic [15:0] vol_mem [MAX_CELLS];
  logic [37:0] trk_mem [MAX_CELLS];
  logic [31:0] val_mem [MAX_CELLS * MAX_COMPONENTS];
  logic [15:0] rd_vol;
  logic [37:0] rd_trk;
  logic [31:0] rd_val;
  logic [CA_W-1:0] rd_cidx;
  logic [VA_W-1:0] rd_vidx;
  logic [CA_W-1:0] wr_cidx;
  logic [VA_W-1:0] wr_vidx;
  logic [31:0] rd_cell32;
  logic [31:0] wr_cell32;
  logic [31:0] rd_val32;
  logic [31:0] wr_val32;
  logic        geom_we;
  logic        val_we;

  // Geometry and working registers.
  logic [4:0]  sxe;
  logic [4:0]  sye;
  logic [4:0]  sze;
  logic [9:0]  plane;
  logic [13:0] total;
  logic [4:0]  cx;
  logic [4:0]  cy;
  logic [4:0]  cz;
  logic [2:0]  ncnt;
  logic [2:0]  nidx;
  logic [34:0] codes;
  logic [12:0] ncell;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  sum_upd;
  logic [VSUM_W-1:0]        sum_vol;

  // Neighbor address path.
  logic [4:0]        code;
  offs_t             off;
  logic signed [6:0] nx;
  logic signed [6:0] ny;
  logic signed [6:0] nz;
  logic              n_bad;
  logic [12:0]       n_addr;

  // Dividers.
  logic             cdiv_start;
  logic [11:0]      cdiv_num;
  logic [4:0]       cdiv_den;
  logic             cdiv_done;
  logic [11:0]      cdiv_quot;
  logic [4:0]       cdiv_rem;
  logic             adiv_start;
  logic [SUM_W-1:0] adiv_num;
  logic             adiv_done;
  logic [SUM_W-1:0] adiv_quot;
  logic [63:0]      quot64;
  logic signed [31:0] avg;

  assign sxe = eff_size(cfg.size_x);
  assign sye = eff_size(cfg.size_y);
  assign sze = eff_size(cfg.size_z);

  // Box plane and volume, two registered products.
  always_ff @(posedge clk) begin
    plane <= 10'(sxe * sye);
    total <= 14'(plane * sze);
  end

  // Store addressing: writes from the dequeued load, reads of own or neighbor cell.
  assign q_pop = (state == S_IDLE) && q_valid;
  assign geom_we = q_pop && (q_item.op == OP_GEOM);
  assign val_we = q_pop && (q_item.op == OP_VALUE);
  assign wr_cell32 = 32'(q_item.addr);
  assign wr_val32 = wr_cell32 * MAX_COMPONENTS + 32'(q_item.comp);
  assign wr_cidx = wr_cell32[CA_W-1:0];
  assign wr_vidx = wr_val32[VA_W-1:0];
  assign rd_cell32 = (state == S_NCHK) ? 32'(ncell) : 32'(cur.addr);
  assign rd_val32 = rd_cell32 * MAX_COMPONENTS + 32'(cur.comp);
  assign rd_cidx = rd_cell32[CA_W-1:0];
  assign rd_vidx = rd_val32[VA_W-1:0];

  always_ff @(posedge clk) begin
    if (geom_we) begin
      vol_mem[wr_cidx] <= q_item.vf;
      trk_mem[wr_cidx] <= {q_item.codes, q_item.cnt};
    end
    rd_vol <= vol_mem[rd_cidx];
    rd_trk <= trk_mem[rd_cidx];
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[wr_vidx] <= q_item.value;
    end
    rd_val <= val_mem[rd_vidx];
  end

  // Neighbor coordinates and linear address for the current code.
  always_comb begin
    code = codes[5*nidx +: 5];
    off = nbr_off(code);
    nx = $signed({2'b00, cx}) + 7'(off.dx);
    ny = $signed({2'b00, cy}) + 7'(off.dy);
    nz = $signed({2'b00, cz}) + 7'(off.dz);
    n_bad = (code == 5'd0) || (code > 5'd26) ||
            (nx < 0) || (ny < 0) || (nz < 0) ||
            (nx >= $signed({2'b00, sxe})) || (ny >= $signed({2'b00, sye})) ||
            (nz >= $signed({2'b00, sze}));
    n_addr = 13'(nx[4:0]) + 13'(ny[4:0]) * 13'(sxe) + 13'(nz[4:0]) * 13'(plane);
  end

  // Coordinate divider: cell / size_x, then quotient / size_y.
  assign cdiv_start = (state == S_ACC0) || ((state == S_DIVX) && cdiv_done);
  assign cdiv_num = (state == S_ACC0) ? cur.addr : cdiv_quot;
  assign cdiv_den = (state == S_ACC0) ? sxe : sye;

  ccma_div #(.NW(12), .DW(5)) u_cdiv (
    .clk(clk), .rst(rst), .start(cdiv_start), .dividend(cdiv_num),
    .divisor(cdiv_den), .done(cdiv_done), .quot(cdiv_quot), .rem(cdiv_rem)
  );

  // Averaging divider works on magnitudes; the sign is applied afterward.
  assign adiv_start = (state == S_FIN) && (32'(sum_vol) >= HALF_VOLUME);
  assign adiv_num = sum_upd[SUM_W-1] ? SUM_W'(-sum_upd) : SUM_W'(sum_upd);

  ccma_div #(.NW(SUM_W), .DW(VSUM_W)) u_adiv (
    .clk(clk), .rst(rst), .start(adiv_start), .dividend(adiv_num),
    .divisor(sum_vol), .done(adiv_done), .quot(adiv_quot), .rem()
  );

  // Truncated quotient with saturation to 32 bits.
  always_comb begin
    quot64 = 64'(adiv_quot);
    if (sum_upd[SUM_W-1]) begin
      if (quot64 > 64'h8000_0000) avg = 32'sh8000_0000;
      else avg = 32'(-$signed(quot64));
    end else begin
      if (quot64 > 64'h7FFF_FFFF) avg = 32'sh7FFF_FFFF;
      else avg = 32'(quot64);
    end
  end

  // Sequencer with registered result outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            if (q_item.op == OP_COMPUTE) state <= S_SETTLE;
          end
        end
        S_SETTLE: state <= S_CHECK;
        S_CHECK: begin
          out_cell <= cur.addr;
          out_comp <= cur.comp;
          if (cur.bad_cell || (total <= 14'(cur.addr))) begin
            done <= 1'b1;
            result_value <= '0;
            status <= ST_OUTSIDE;
            state <= S_IDLE;
          end else if (cur.bad_comp) begin
            done <= 1'b1;
            result_value <= '0;
            status <= ST_BAD_COMP;
            state <= S_IDLE;
          end else begin
            state <= S_OWN;
          end
        end
        S_OWN: begin
          ncnt <= (rd_trk[2:0] > NB_CAP) ? NB_CAP : rd_trk[2:0];
          codes <= rd_trk[37:3];
          nidx <= 3'd0;
          sum_vol <= VSUM_W'(rd_vol);
          prod <= PROD_W'($signed({1'b0, rd_vol}) * $signed(rd_val));
          if (rd_vol == 16'd0) begin
            done <= 1'b1;
            result_value <= SENTINEL;
            status <= ST_COVERED;
            state <= S_IDLE;
          end else if (rd_trk[2:0] == 3'd0) begin
            done <= 1'b1;
            result_value <= rd_val;
            status <= ST_PASSED;
            state <= S_IDLE;
          end else begin
            state <= S_ACC0;
          end
        end
        S_ACC0: begin
          sum_upd <= SUM_W'(prod);
          state <= S_DIVX;
        end
        S_DIVX: begin
          if (cdiv_done) begin
            cx <= cdiv_rem;
            state <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (cdiv_done) begin
            cy <= cdiv_rem;
            cz <= cdiv_quot[4:0];
            state <= S_NCODE;
          end
        end
        S_NCODE: begin
          ncell <= n_addr;
          if (n_bad) begin
            done <= 1'b1;
            result_value <= '0;
            status <= ST_OUTSIDE;
            state <= S_IDLE;
          end else begin
            state <= S_NCHK;
          end
        end
        S_NCHK: begin
          if (32'(ncell) >= MAX_CELLS) begin
            done <= 1'b1;
            result_value <= '0;
            status <= ST_OUTSIDE;
            state <= S_IDLE;
          end else begin
            state <= S_NDATA;
          end
        end
        S_NDATA: begin
          sum_vol <= sum_vol + VSUM_W'(rd_vol);
          prod <= PROD_W'($signed({1'b0, rd_vol}) * $signed(rd_val));
          state <= S_NACC;
        end
        S_NACC: begin
          sum_upd <= sum_upd + SUM_W'(prod);
          nidx <= nidx + 3'd1;
          state <= (nidx + 3'd1 == ncnt) ? S_FIN : S_NCODE;
        end
        S_FIN: begin
          if (32'(sum_vol) < HALF_VOLUME) begin
            done <= 1'b1;
            result_value <= '0;
            status <= ST_LOW_VOL;
            state <= S_IDLE;
          end else begin
            state <= S_DIVA;
          end
        end
        S_DIVA: begin
          if (adiv_done) begin
            done <= 1'b1;
            result_value <= avg;
            status <= ST_AVERAGED;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // Result pulses never come back to back.
  a_done_gap: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("back-to-back results");
  // A covered cell always carries the sentinel value.
  a_covered: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_COVERED) |-> (result_value == SENTINEL))
    else $error("covered result without sentinel");
  // Neighbor accumulation never runs past the tracked count.
  a_nidx: assert property (@(posedge clk) disable iff (rst)
    (state == S_NACC) |-> (nidx < ncnt))
    else $error("neighbor index beyond count");
`endif

endmodule
`default_nettype wire
